FILE: sv/gbc_pkg.sv
// shared types and constants of the gyro bias calibrator
package gbc_pkg;

  // field and register widths, the axis count and the minimum sample count
  localparam int OUT_W       = 16;
  localparam int CFG_COUNT_W = 11;
  localparam int THR_W       = 30;
  localparam int CFG_DATA_W  = 30;
  localparam int CFG_IDX_W   = 1;
  localparam int AXES        = 3;
  localparam int MIN_COUNT   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_THRESHOLD = 1'b1;

  // register reset values
  localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = 11'd200;
  localparam logic [THR_W-1:0]       THR_RESET   = 30'd1024;

  // 16-bit saturation limits
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

  // sequencer strobes shared by the lanes and the merge stage
  typedef struct packed {
    logic sample_load;  // latch a new sample and its square
    logic accum;        // add the latched sample into the sums
    logic clear;        // start the sums from zero (restart)
    logic load1;        // check: load n * sum2 operands
    logic run1;         // check: shift-add step of the first product
    logic load2;        // check: load sum^2 operands
    logic run2;         // check: shift-subtract step of the second product
    logic sub_lim;      // check: subtract threshold * n^2
  } gbc_ctl_t;

endpackage

FILE: sv/gbc_lane.sv
// one axis lane: sum and sum of squares, then the shift-add variance check
module gbc_lane #(
  parameter int SAMPLE_BITS = 16,
  parameter int CW          = 11,
  parameter int SUMW        = 27,
  parameter int SQW         = 41,
  parameter int DW          = 56
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gbc_pkg::gbc_ctl_t             ctl,
  input  logic signed [SAMPLE_BITS-1:0] rate,
  input  logic [CW-1:0]                 n,
  input  logic [DW-1:0]                 limit,
  output logic signed [SUMW-1:0]        sum,
  output logic                          neg
);
  import gbc_pkg::*;

  localparam int SQIN_W = 2 * SAMPLE_BITS - 1;

  logic signed [SAMPLE_BITS-1:0] samp;
  logic [SQIN_W-1:0]             sqr;
  logic [SQW-1:0]                sqsum;
  logic [SAMPLE_BITS-1:0]        rate_mag;
  logic [2*SAMPLE_BITS-1:0]      rate_sq;
  logic signed [SUMW-1:0]        sum_base;
  logic [SQW-1:0]                sq_base;
  logic [SUMW-1:0]               sum_mag;
  logic [DW-1:0]                 acc;
  logic [DW-1:0]                 addend;
  logic [SUMW-1:0]               opnd;
  logic                          spread_neg;

  // square of the incoming sample magnitude
  assign rate_mag = rate[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rate) : SAMPLE_BITS'(rate);
  assign rate_sq  = rate_mag * rate_mag;

  // restart starts the sums over
  assign sum_base = ctl.clear ? '0 : sum;
  assign sq_base  = ctl.clear ? '0 : sqsum;
  assign sum_mag  = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);

  // sample and square registers
  always_ff @(posedge clk) begin
    if (ctl.sample_load) begin
      samp <= rate;
      sqr  <= rate_sq[SQIN_W-1:0];
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sqsum <= '0;
    end else if (ctl.accum) begin
      sum   <= sum_base + SUMW'(samp);
      sqsum <= sq_base + SQW'(sqr);
    end
  end

  // n * sum2 - sum^2 - limit, one operand bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      acc    <= '0;
      opnd   <= SUMW'(n);
      addend <= DW'(sqsum);
    end else if (ctl.run1) begin
      if (opnd[0]) begin
        acc <= acc + addend;
      end
      addend <= addend << 1;
      opnd   <= opnd >> 1;
    end else if (ctl.load2) begin
      opnd   <= sum_mag;
      addend <= DW'(sum_mag);
    end else if (ctl.run2) begin
      if (opnd[0]) begin
        acc <= acc - addend;
      end
      addend <= addend << 1;
      opnd   <= opnd >> 1;
    end else if (ctl.sub_lim) begin
      acc        <= acc - limit;
      spread_neg <= acc[DW-1];
    end
  end

  // the axis passes when its spread is not negative and lies below the limit
  assign neg = acc[DW-1] && !spread_neg;

endmodule

FILE: sv/gbc_merge.sv
// merge stage: threshold * n^2, z mean divider and the per-axis verdict
module gbc_merge #(
  parameter int CW   = 11,
  parameter int SUMW = 27,
  parameter int DW   = 56
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gbc_pkg::gbc_ctl_t            ctl,
  input  logic [CW-1:0]                n,
  input  logic [gbc_pkg::THR_W-1:0]    thr,
  input  logic signed [SUMW-1:0]       sum_z,
  input  logic [gbc_pkg::AXES-1:0]     lane_neg,
  output logic [DW-1:0]                limit,
  output logic [gbc_pkg::AXES-1:0]     fails,
  output logic signed [gbc_pkg::OUT_W-1:0] bias_q
);
  import gbc_pkg::*;

  localparam int DCW = $clog2(SUMW + 1);
  localparam int QX  = ((SUMW > OUT_W) ? SUMW : OUT_W) + 1;

  logic [DW-1:0]   lacc;
  logic [DW-1:0]   laddend;
  logic [CW-1:0]   lopnd;
  logic [DCW-1:0]  dcnt;
  logic [CW-1:0]   drem;
  logic [SUMW-1:0] dquo;
  logic            dneg;
  logic [CW+1:0]   div_diff;
  logic            div_fit;
  logic [SUMW-1:0] sum_z_mag;
  logic [QX-1:0]   q_ext;
  logic [QX-1:0]   q_negx;
  logic            pos_sat;
  logic            neg_sat;

  // threshold * n, then that times n, by shift-add
  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      lacc    <= '0;
      lopnd   <= n;
      laddend <= DW'(thr);
    end else if (ctl.load2) begin
      lacc    <= '0;
      lopnd   <= n;
      laddend <= lacc;
    end else if (ctl.run1 || ctl.run2) begin
      if (lopnd[0]) begin
        lacc <= lacc + laddend;
      end
      laddend <= laddend << 1;
      lopnd   <= lopnd >> 1;
    end
  end

  assign limit = lacc;

  // restoring divider for |sum_z| / n, one quotient bit per cycle
  assign sum_z_mag = sum_z[SUMW-1] ? SUMW'(-sum_z) : SUMW'(sum_z);
  assign div_diff  = {1'b0, drem, dquo[SUMW-1]} - {2'b00, n};
  assign div_fit   = !div_diff[CW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (ctl.load1) begin
      dcnt <= DCW'(SUMW);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      drem <= '0;
      dquo <= sum_z_mag;
      dneg <= sum_z[SUMW-1];
    end else if (dcnt != '0) begin
      drem <= div_fit ? div_diff[CW-1:0] : {drem[CW-2:0], dquo[SUMW-1]};
      dquo <= {dquo[SUMW-2:0], div_fit};
    end
  end

  // signed mean, truncated toward zero, saturated to 16 bits
  assign q_ext   = QX'(dquo);
  assign q_negx  = -q_ext;
  assign pos_sat = q_ext > QX'(32767);
  assign neg_sat = q_ext > QX'(32768);

  always_comb begin
    if (dneg) begin
      bias_q = neg_sat ? OUT_MIN : q_negx[OUT_W-1:0];
    end else begin
      bias_q = pos_sat ? OUT_MAX : q_ext[OUT_W-1:0];
    end
  end

  // an axis fails when its spread is negative or not below the limit
  assign fails = ~lane_neg;

endmodule

FILE: sv/gyro_bias_calibrator_unit.sv
// top level of the gyro bias calibrator: control, configuration, result register
// Gyro bias calibrator. Each transfer on the sample channel carries one x/y/z
// rate sample and gives one result transfer: the z rate minus the current bias,
// saturated to 16 bits, together with the bias, the calibrated flag and, on the
// sample that ends a calibration run, cal_done and the per-axis fail bits. A
// run takes sample_count samples (clamped to 2..MAX_SAMPLES), starts at reset
// and again on a sample with restart set. One item is in flight at a time:
// an ordinary sample passes through the accumulate and finish states into the
// result register, and the block then returns to idle for the next sample.
// The sample that ends a run passes through the check state in between, where
// the three axis lanes run the shift-add variance check and the bit-serial
// divider for the z mean runs next to it. A new sample is taken while the
// previous result still waits in the output register.
module gyro_bias_calibrator_unit #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]        rate_x,
  input  logic signed [SAMPLE_BITS-1:0]        rate_y,
  input  logic signed [SAMPLE_BITS-1:0]        rate_z,
  input  logic                                 restart,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [gbc_pkg::OUT_W-1:0]     corrected_z,
  output logic                                 calibrated,
  output logic                                 cal_done,
  output logic signed [gbc_pkg::OUT_W-1:0]     bias_z,
  output logic [gbc_pkg::AXES-1:0]             axis_fail,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import gbc_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int SQW  = 2 * SAMPLE_BITS - 2 + CW;
  localparam int DW_A = CW + SQW;
  localparam int DW_B = 2 * SUMW;
  localparam int DW_C = THR_W + 2 * CW;
  localparam int DW_AB = (DW_A > DW_B) ? DW_A : DW_B;
  localparam int DW   = ((DW_AB > DW_C) ? DW_AB : DW_C) + 2;
  localparam int LAST = CW + SUMW + 2;
  localparam int SW   = $clog2(LAST + 1);
  localparam int DZ   = ((SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W) + 1;
  localparam logic signed [DZ-1:0] Z_MAX = DZ'(32767);
  localparam logic signed [DZ-1:0] Z_MIN = DZ'(-32768);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ACC   = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t                         state;
  logic [SW-1:0]                  step;
  logic [CW-1:0]                  cnt;
  logic                           run_finished;
  logic                           pass;
  logic signed [OUT_W-1:0]        bias;
  logic [CFG_COUNT_W-1:0]         sample_count;
  logic [THR_W-1:0]               var_threshold;
  logic                           restart_q;
  logic signed [SAMPLE_BITS-1:0]  z_hold;
  logic                           done_q;

  logic [31:0]                    n_wide;
  logic [CW-1:0]                  n_eff;
  logic [CW-1:0]                  cnt_base;
  logic [CW-1:0]                  cnt_inc;
  logic                           run_done;
  logic                           accum_en;
  logic                           out_free;
  gbc_ctl_t                       ctl;

  logic signed [SAMPLE_BITS-1:0]  lane_rate [AXES];
  logic signed [SUMW-1:0]         lane_sum [AXES];
  logic [AXES-1:0]                lane_neg;
  logic [DW-1:0]                  limit;
  logic [AXES-1:0]                fails;
  logic signed [OUT_W-1:0]        bias_q;

  logic                           pass_chk;
  logic                           pass_new;
  logic signed [OUT_W-1:0]        bias_new;
  logic signed [DZ-1:0]           z_diff;
  logic signed [OUT_W-1:0]        z_corr;

  // effective sample count
  always_comb begin
    if (sample_count < CFG_COUNT_W'(MIN_COUNT)) begin
      n_wide = 32'(MIN_COUNT);
    end else if (32'(sample_count) > 32'(MAX_SAMPLES)) begin
      n_wide = 32'(MAX_SAMPLES);
    end else begin
      n_wide = 32'(sample_count);
    end
  end
  assign n_eff = n_wide[CW-1:0];

  // sample counter update
  assign cnt_base = restart_q ? '0 : cnt;
  assign cnt_inc  = cnt_base + 1'b1;
  assign run_done = cnt_inc >= n_eff;
  assign accum_en = restart_q || !run_finished;

  // handshake
  assign sample_stall = (state != ST_IDLE);
  assign out_free     = !result_valid || !result_stall;

  // sequencer strobes
  always_comb begin
    ctl             = '0;
    ctl.sample_load = (state == ST_IDLE) && sample_valid;
    ctl.accum       = (state == ST_ACC) && accum_en;
    ctl.clear       = (state == ST_ACC) && restart_q;
    ctl.load1       = (state == ST_CHECK) && (step == '0);
    ctl.run1        = (state == ST_CHECK) && (step >= SW'(1)) && (step <= SW'(CW));
    ctl.load2       = (state == ST_CHECK) && (step == SW'(CW + 1));
    ctl.run2        = (state == ST_CHECK) && (step >= SW'(CW + 2))
                      && (step <= SW'(CW + 1 + SUMW));
    ctl.sub_lim     = (state == ST_CHECK) && (step == SW'(LAST));
  end

  // axis lanes
  assign lane_rate[0] = rate_x;
  assign lane_rate[1] = rate_y;
  assign lane_rate[2] = rate_z;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    gbc_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CW          (CW),
      .SUMW        (SUMW),
      .SQW         (SQW),
      .DW          (DW)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .rate  (lane_rate[a]),
      .n     (n_eff),
      .limit (limit),
      .sum   (lane_sum[a]),
      .neg   (lane_neg[a])
    );
  end

  // limit, z mean and verdict
  gbc_merge #(
    .CW   (CW),
    .SUMW (SUMW),
    .DW   (DW)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .n        (n_eff),
    .thr      (var_threshold),
    .sum_z    (lane_sum[2]),
    .lane_neg (lane_neg),
    .limit    (limit),
    .fails    (fails),
    .bias_q   (bias_q)
  );

  // bias after this item and the corrected rate
  assign pass_chk = (fails == '0);
  assign pass_new = done_q ? pass_chk : pass;
  assign bias_new = done_q ? (pass_chk ? bias_q : '0) : bias;
  assign z_diff   = DZ'(z_hold) - DZ'(bias_new);

  always_comb begin
    if (z_diff > Z_MAX) begin
      z_corr = OUT_MAX;
    end else if (z_diff < Z_MIN) begin
      z_corr = OUT_MIN;
    end else begin
      z_corr = z_diff[OUT_W-1:0];
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      cnt           <= '0;
      run_finished  <= 1'b0;
      pass          <= 1'b0;
      bias          <= '0;
      result_valid  <= 1'b0;
      sample_count  <= COUNT_RESET;
      var_threshold <= THR_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SAMPLE_COUNT:  sample_count  <= cfg_data[CFG_COUNT_W-1:0];
          REG_VAR_THRESHOLD: var_threshold <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (accum_en) begin
            cnt <= cnt_inc;
          end
          if (restart_q) begin
            run_finished <= 1'b0;
          end
          if (accum_en && run_done) begin
            run_finished <= 1'b1;
            step         <= '0;
            state        <= ST_CHECK;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_CHECK: begin
          step <= step + 1'b1;
          if (step == SW'(LAST)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (done_q) begin
              bias <= bias_new;
              pass <= pass_new;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload and result register
  always_ff @(posedge clk) begin
    if (ctl.sample_load) begin
      z_hold    <= rate_z;
      restart_q <= restart;
    end
    if (state == ST_ACC) begin
      done_q <= accum_en && run_done;
    end
    if ((state == ST_FIN) && out_free) begin
      corrected_z <= z_corr;
      calibrated  <= pass_new;
      cal_done    <= done_q;
      bias_z      <= bias_new;
      axis_fail   <= done_q ? fails : '0;
    end
  end

  // checks
  a_done_flag_match: assert property (@(posedge clk) disable iff (rst)
    (result_valid && cal_done) |-> (calibrated == (axis_fail == '0)))
    else $error("calibrated flag disagrees with axis fail bits");

  a_fail_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !cal_done) |-> (axis_fail == '0))
    else $error("axis fail bits set without a finished run");

  a_uncal_zero_bias: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !calibrated) |-> (bias_z == '0))
    else $error("nonzero bias while not calibrated");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= 32'(MAX_SAMPLES))
    else $error("sample counter beyond its maximum");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the gyro bias calibrator unit
`timescale 1ns / 1ps

module testbench;
  import gbc_pkg::*;

  localparam int MAX_SAMPLES = 1024;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 20;

  typedef struct packed {
    logic signed [OUT_W-1:0] corrected;
    logic                    calibrated;
    logic                    done;
    logic signed [OUT_W-1:0] bias;
    logic [AXES-1:0]         fail;
  } cal_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  // block ports
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic signed [15:0]      rate_x = '0;
  logic signed [15:0]      rate_y = '0;
  logic signed [15:0]      rate_z = '0;
  logic                    restart = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [OUT_W-1:0] corrected_z;
  logic                    calibrated;
  logic                    cal_done;
  logic signed [OUT_W-1:0] bias_z;
  logic [AXES-1:0]         axis_fail;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  gyro_bias_calibrator_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .rate_x       (rate_x),
    .rate_y       (rate_y),
    .rate_z       (rate_z),
    .restart      (restart),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .corrected_z  (corrected_z),
    .calibrated   (calibrated),
    .cal_done     (cal_done),
    .bias_z       (bias_z),
    .axis_fail    (axis_fail),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // idling control and run statistics
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int runs_ended = 0;
  int runs_passed = 0;
  int mismatch_count = 0;

  cal_result_t pending_results[$];

  // calibrator state as the block should hold it
  logic [CFG_COUNT_W-1:0]  model_count = COUNT_RESET;
  logic [THR_W-1:0]        model_threshold = THR_RESET;
  int                      run_taken = 0;
  longint                  axis_total [AXES] = '{default: 0};
  longint                  axis_energy [AXES] = '{default: 0};
  logic signed [OUT_W-1:0] held_bias = '0;
  logic                    held_pass = 1'b0;
  logic                    run_closed = 1'b0;

  function automatic logic signed [OUT_W-1:0] clip16(input longint v);
    if (v > 32767) return OUT_MAX;
    if (v < -32768) return OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // advance the calibrator by one sample and return the result it gives
  function automatic cal_result_t calibrate_step(input logic signed [15:0] rx,
                                                 input logic signed [15:0] ry,
                                                 input logic signed [15:0] rz,
                                                 input logic rs);
    longint      smp [AXES];
    longint      lim;
    longint      spread;
    int          n;
    cal_result_t res;
    smp[0] = rx;
    smp[1] = ry;
    smp[2] = rz;
    res = '0;
    if (rs) begin
      run_taken = 0;
      for (int a = 0; a < AXES; a++) begin
        axis_total[a] = 0;
        axis_energy[a] = 0;
      end
      run_closed = 1'b0;
    end
    if (!run_closed) begin
      // effective count is clamped to the supported range
      n = model_count;
      if (n < MIN_COUNT) n = MIN_COUNT;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      for (int a = 0; a < AXES; a++) begin
        axis_total[a] += smp[a];
        axis_energy[a] += smp[a] * smp[a];
      end
      run_taken++;
      if (run_taken >= n) begin
        // exact integer variance test per axis; a negative spread counts as a failure
        lim = longint'(model_threshold) * n * n;
        for (int a = 0; a < AXES; a++) begin
          spread = n * axis_energy[a] - axis_total[a] * axis_total[a];
          if (spread < 0 || spread >= lim) res.fail[a] = 1'b1;
        end
        if (res.fail == '0) begin
          held_bias = clip16(axis_total[2] / n);
          held_pass = 1'b1;
        end else begin
          held_bias = '0;
          held_pass = 1'b0;
        end
        run_closed = 1'b1;
        res.done = 1'b1;
      end
    end
    res.corrected = clip16(smp[2] - held_bias);
    res.calibrated = held_pass;
    res.bias = held_bias;
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // result channel stall pattern
  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    cal_result_t want;
    cal_result_t got;
    string       bad;
    if (!rst && result_valid && !result_stall) begin
      got = '{corrected_z, calibrated, cal_done, bias_z, axis_fail};
      results_seen++;
      if (got.done) begin
        runs_ended++;
        if (got.calibrated) runs_passed++;
      end
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result corr=%0d cal=%0b done=%0b bias=%0d fail=%03b",
                                got.corrected, got.calibrated, got.done, got.bias, got.fail));
      end else begin
        want = pending_results.pop_front();
        bad = "";
        if (got.corrected !== want.corrected) bad = {bad, " corrected_z"};
        if (got.calibrated !== want.calibrated) bad = {bad, " calibrated"};
        if (got.done !== want.done) bad = {bad, " cal_done"};
        if (got.bias !== want.bias) bad = {bad, " bias_z"};
        if (got.fail !== want.fail) bad = {bad, " axis_fail"};
        if (bad != "") begin
          note_mismatch({
            $sformatf("result %0d%s: exp corr=%0d cal=%0b done=%0b bias=%0d fail=%03b",
                      results_seen, bad, want.corrected, want.calibrated, want.done,
                      want.bias, want.fail),
            $sformatf(", got corr=%0d cal=%0b done=%0b bias=%0d fail=%03b",
                      got.corrected, got.calibrated, got.done, got.bias, got.fail)});
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at cycle limit with %0d results pending", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one sample transfer, with a random gap before it
  task automatic send_sample(input logic signed [15:0] rx, input logic signed [15:0] ry,
                             input logic signed [15:0] rz, input logic rs);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    rate_x <= rx;
    rate_y <= ry;
    rate_z <= rz;
    restart <= rs;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_results.push_back(calibrate_step(rx, ry, rz, rs));
    samples_sent++;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // register write, only once the block has gone idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    sample_valid <= 1'b0;
    wait_drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_SAMPLE_COUNT) model_count = data[CFG_COUNT_W-1:0];
    else model_threshold = data[THR_W-1:0];
  endtask

  // default settings from reset, then the count lowered below the samples taken
  task automatic test_power_up_run();
    idle_pct = 0;
    stall_pct = 0;
    repeat (4) send_sample(16'sd5, -16'sd3, 16'sd7, 1'b0);
    write_reg(REG_SAMPLE_COUNT, 30'd3);
    send_sample(16'sd5, -16'sd3, 16'sd7, 1'b0);
    send_sample(16'sd100, 16'sd100, -16'sd32768, 1'b0);
  endtask

  // counts below the minimum, count with junk above its width, output saturation
  task automatic test_count_clamps();
    write_reg(REG_SAMPLE_COUNT, 30'd0);
    write_reg(REG_VAR_THRESHOLD, 30'd1);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_sample(16'sd0, 16'sd0, -16'sd32768, 1'b0);
    write_reg(REG_SAMPLE_COUNT, 30'd1);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd32767, 1'b0);
    write_reg(REG_SAMPLE_COUNT, 30'h3fff_f803);
    send_sample(16'sd1, 16'sd2, 16'sd3, 1'b1);
    send_sample(16'sd1, 16'sd2, 16'sd3, 1'b0);
    send_sample(16'sd1, 16'sd2, 16'sd3, 1'b0);
  endtask

  // zero threshold fails every axis, full threshold passes full swings, one axis noisy
  task automatic test_threshold_extremes();
    write_reg(REG_SAMPLE_COUNT, 30'd2);
    write_reg(REG_VAR_THRESHOLD, 30'd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
    write_reg(REG_SAMPLE_COUNT, 30'd4);
    write_reg(REG_VAR_THRESHOLD, 30'h3fff_ffff);
    for (int i = 0; i < 4; i++) begin
      if (i % 2 == 0) send_sample(-16'sd32768, 16'sd32767, -16'sd32768, i == 0);
      else send_sample(16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
    end
    write_reg(REG_SAMPLE_COUNT, 30'd3);
    write_reg(REG_VAR_THRESHOLD, 30'd100);
    send_sample(16'sd10, -16'sd500, -16'sd1, 1'b1);
    send_sample(16'sd10, 16'sd0, -16'sd1, 1'b0);
    send_sample(16'sd10, 16'sd500, -16'sd1, 1'b0);
  endtask

  // negative mean truncates toward zero; bias holds through a restarted run
  task automatic test_restart_keeps_bias();
    write_reg(REG_VAR_THRESHOLD, 30'd1024);
    send_sample(16'sd0, 16'sd0, -16'sd1, 1'b1);
    send_sample(16'sd0, 16'sd0, -16'sd1, 1'b0);
    send_sample(16'sd0, 16'sd0, -16'sd2, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd50, 1'b1);
    send_sample(16'sd0, 16'sd0, 16'sd60, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd70, 1'b1);
    send_sample(16'sd0, 16'sd0, 16'sd70, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd70, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
  endtask

  // count far above the supported maximum: the run must end at the maximum
  task automatic test_count_ceiling();
    idle_pct = 31;
    stall_pct = 31;
    write_reg(REG_SAMPLE_COUNT, 30'h7ff);
    write_reg(REG_VAR_THRESHOLD, 30'd400);
    for (int i = 0; i <= MAX_SAMPLES; i++) begin
      send_sample(clip16(int'($urandom_range(0, 20)) - 10),
                  clip16(int'($urandom_range(0, 20)) - 30),
                  clip16(int'($urandom_range(0, 20)) + 113), i == 0);
    end
  endtask

  // one calibration run with random settings and random content, sometimes broken
  task automatic cal_run();
    longint           center [AXES];
    int               count_cfg;
    int               eff;
    int               amp;
    int               jitter;
    int               restart_at;
    int               pick;
    logic [THR_W-1:0] thr;
    logic signed [15:0] smp [AXES];
    pick = $urandom_range(99);
    if (pick < 5) count_cfg = $urandom_range(0, 1);
    else if (pick < 85) count_cfg = $urandom_range(2, 10);
    else count_cfg = $urandom_range(11, 48);
    eff = (count_cfg < MIN_COUNT) ? MIN_COUNT : count_cfg;
    case ($urandom_range(3))
      0: amp = 0;
      1: amp = $urandom_range(1, 8);
      2: amp = $urandom_range(9, 64);
      default: amp = $urandom_range(65, 2000);
    endcase
    pick = $urandom_range(99);
    if (pick < 10) thr = '0;
    else if (pick < 20) thr = '1;
    else thr = THR_W'((amp * amp / 3) * $urandom_range(25, 200) / 100
                      + $urandom_range(0, 2));
    for (int a = 0; a < AXES; a++) begin
      if ($urandom_range(99) < 20) center[a] = longint'($urandom_range(0, 65535)) - 32768;
      else center[a] = longint'($urandom_range(0, 400)) - 200;
    end
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(count_cfg));
    write_reg(REG_VAR_THRESHOLD, thr);
    // a broken run restarts partway and then runs to completion
    restart_at = ($urandom_range(99) < 15) ? $urandom_range(1, eff) : 0;
    for (int i = 0; i < eff + restart_at + $urandom_range(0, 2); i++) begin
      for (int a = 0; a < AXES; a++) begin
        jitter = $urandom_range(0, 2 * amp);
        smp[a] = clip16(center[a] + jitter - amp);
      end
      send_sample(smp[0], smp[1], smp[2], i == 0 || (restart_at != 0 && i == restart_at));
    end
  endtask

  // full-range samples with occasional restarts
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      send_sample(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), $urandom_range(99) < 15);
    end
  endtask

  task automatic test_random_phase(input int sender_idle, input int receiver_stall);
    int start_count;
    sample_valid <= 1'b0;
    wait_drain();
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    start_count = samples_sent;
    while (samples_sent - start_count < PHASE_ITEMS) begin
      if ($urandom_range(99) < 80) cal_run();
      else noise_burst();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_power_up_run();
    test_count_clamps();
    test_threshold_extremes();
    test_restart_keeps_bias();
    test_count_ceiling();
    test_random_phase(0, 0);
    test_random_phase(48, 0);
    test_random_phase(0, 48);
    test_random_phase(31, 31);
    sample_valid <= 1'b0;
    wait_drain();
    repeat (60) @(posedge clk);
    $display("covered %0d samples and %0d checked results over directed and random phases",
             samples_sent, results_seen);
    $display("%0d calibration runs ended, %0d passed the variance check, %0d mismatches",
             runs_ended, runs_passed, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d predicted results never arrived", pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/gbc_pkg.sv
sv/gbc_lane.sv
sv/gbc_merge.sv
sv/gyro_bias_calibrator_unit.sv
tb/testbench.sv
